[hdl/tipt_pkg.sv]
`timescale 1ns / 1ps
package tipt_pkg;

  localparam int IdW    = 64;
  localparam int TimeW  = 64;
  localparam int ToW    = 32;
  localparam int WordW  = 4 * IdW + TimeW;

  localparam logic [2:0] CMD_ADD        = 3'd0;
  localparam logic [2:0] CMD_ADD_ABSENT = 3'd1;
  localparam logic [2:0] CMD_LOOKUP     = 3'd2;
  localparam logic [2:0] CMD_REMOVE     = 3'd3;
  localparam logic [2:0] CMD_PURGE      = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_CMPCT_RD,
    ST_CMPCT_WR,
    ST_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic search_init;
    logic idx_inc;
    logic erase_init;
    logic purge_init;
    logic compact_step;
    logic append;
    logic clear;
    logic set_answer;
    logic set_dropped;
    logic out_load;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic       cnt_zero;
    logic       full;
    logic       idx_last;
    logic       match;
    logic       expired;
    logic       to_zero;
    logic       out_busy;
  } dp_sts_t;

endpackage

[hdl/tipt_ctrl.sv]
`timescale 1ns / 1ps
module tipt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tipt_pkg::dp_sts_t  sts,
  output tipt_pkg::ctl_cmd_t cmd
);
  import tipt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_nxt = ST_RESULT;
        case (sts.command)
          CMD_ADD_ABSENT, CMD_LOOKUP, CMD_REMOVE: begin
            if (!sts.cnt_zero) state_nxt = ST_SRCH_RD;
          end
          CMD_PURGE: begin
            if (!sts.cnt_zero) state_nxt = ST_CMPCT_RD;
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_SRCH_RD: state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (sts.match) begin
          state_nxt = ST_RESULT;
          if (sts.command == CMD_REMOVE) state_nxt = ST_CMPCT_RD;
          if (sts.command == CMD_LOOKUP && !sts.to_zero && sts.expired)
            state_nxt = ST_CMPCT_RD;
        end else if (sts.idx_last) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_CMPCT_RD: state_nxt = ST_CMPCT_WR;
      ST_CMPCT_WR: state_nxt = sts.idx_last ? ST_RESULT : ST_CMPCT_RD;
      ST_RESULT: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DISPATCH: begin
        case (sts.command)
          CMD_ADD: begin
            if (sts.full) cmd.set_dropped = 1'b1;
            else cmd.append = 1'b1;
          end
          CMD_ADD_ABSENT: begin
            if (sts.cnt_zero) begin
              cmd.append     = 1'b1;
              cmd.set_answer = 1'b1;
            end else begin
              cmd.search_init = 1'b1;
            end
          end
          CMD_LOOKUP, CMD_REMOVE: cmd.search_init = !sts.cnt_zero;
          CMD_PURGE:  cmd.purge_init = !sts.cnt_zero;
          CMD_CLEAR:  cmd.clear = 1'b1;
          default: ;
        endcase
      end
      ST_SRCH_CMP: begin
        if (sts.match) begin
          case (sts.command)
            CMD_LOOKUP: begin
              if (!sts.to_zero && sts.expired) cmd.erase_init = 1'b1;
              else cmd.set_answer = 1'b1;
            end
            CMD_REMOVE: begin
              cmd.set_answer = 1'b1;
              cmd.erase_init = 1'b1;
            end
            default: ;
          endcase
        end else if (sts.idx_last) begin
          if (sts.command == CMD_ADD_ABSENT) begin
            if (sts.full) begin
              cmd.set_dropped = 1'b1;
            end else begin
              cmd.append     = 1'b1;
              cmd.set_answer = 1'b1;
            end
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_CMPCT_WR: cmd.compact_step = 1'b1;
      ST_RESULT:   cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

[hdl/tipt_dpath.sv]
`timescale 1ns / 1ps
module tipt_dpath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tipt_pkg::ctl_cmd_t          cmd,
  output tipt_pkg::dp_sts_t           sts,
  input  logic [2:0]                  in_command,
  input  logic [tipt_pkg::IdW-1:0]    in_first_id_high,
  input  logic [tipt_pkg::IdW-1:0]    in_first_id_low,
  input  logic [tipt_pkg::IdW-1:0]    in_second_id_high,
  input  logic [tipt_pkg::IdW-1:0]    in_second_id_low,
  input  logic [tipt_pkg::TimeW-1:0]  in_now_ms,
  input  logic [tipt_pkg::ToW-1:0]    in_timeout_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_answer,
  output logic                        out_dropped_full,
  output logic [6:0]                  out_entries_used
);
  import tipt_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [WordW-1:0] mem [TABLE_ENTRIES];
  logic [WordW-1:0] rdata_r;

  logic [2:0]       cmd_r;
  logic [IdW-1:0]   f_hi_r, f_lo_r, s_hi_r, s_lo_r;
  logic [TimeW-1:0] now_r;
  logic [ToW-1:0]   to_r;
  logic [CW-1:0]    count_r;
  logic [AW-1:0]    idx_r, wptr_r, pos_r;
  logic             purge_r, ans_r, drop_r;
  logic             out_valid_r, out_ans_r, out_drop_r;
  logic [6:0]       out_used_r;

  logic [CW-1:0]    idx_p1;
  logic [TimeW:0]   limit;
  logic             expired, keep;
  logic [CW+6:0]    used_ext;

  assign idx_p1  = CW'(idx_r) + CW'(1);
  // stamp + timeout without wraparound
  assign limit   = {1'b0, rdata_r[TimeW-1:0]} + {{(TimeW-ToW+1){1'b0}}, to_r};
  assign expired = limit < {1'b0, now_r};
  assign keep    = purge_r ? !expired : (idx_r != pos_r);

  assign sts.command  = cmd_r;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.full     = (count_r >= CW'(TABLE_ENTRIES));
  assign sts.idx_last = (idx_p1 >= count_r);
  assign sts.match    = (rdata_r[WordW-1 -: IdW]         == f_hi_r) &&
                        (rdata_r[WordW-1-IdW -: IdW]     == f_lo_r) &&
                        (rdata_r[WordW-1-2*IdW -: IdW]   == s_hi_r) &&
                        (rdata_r[WordW-1-3*IdW -: IdW]   == s_lo_r);
  assign sts.expired  = expired;
  assign sts.to_zero  = (to_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  // table storage: single write port, registered read at idx_r
  always_ff @(posedge clk) begin
    rdata_r <= mem[idx_r];
    if (cmd.append) begin
      mem[count_r[AW-1:0]] <= {f_hi_r, f_lo_r, s_hi_r, s_lo_r, now_r};
    end else if (cmd.compact_step && keep) begin
      mem[wptr_r] <= rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      f_hi_r <= in_first_id_high;
      f_lo_r <= in_first_id_low;
      s_hi_r <= in_second_id_high;
      s_lo_r <= in_second_id_low;
      now_r  <= in_now_ms;
      to_r   <= in_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      wptr_r      <= '0;
      pos_r       <= '0;
      purge_r     <= 1'b0;
      ans_r       <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ans_r  <= 1'b0;
        drop_r <= 1'b0;
      end
      if (cmd.set_answer)  ans_r  <= 1'b1;
      if (cmd.set_dropped) drop_r <= 1'b1;
      if (cmd.search_init) idx_r <= '0;
      if (cmd.idx_inc)     idx_r <= idx_r + AW'(1);
      if (cmd.erase_init) begin
        purge_r <= 1'b0;
        pos_r   <= idx_r;
        wptr_r  <= idx_r;
      end
      if (cmd.purge_init) begin
        purge_r <= 1'b1;
        idx_r   <= '0;
        wptr_r  <= '0;
      end
      if (cmd.compact_step) begin
        idx_r  <= idx_r + AW'(1);
        wptr_r <= wptr_r + AW'(keep);
        if (sts.idx_last) count_r <= CW'(wptr_r) + CW'(keep);
      end
      if (cmd.append) count_r <= count_r + CW'(1);
      if (cmd.clear)  count_r <= '0;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign used_ext = {7'b0, count_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ans_r  <= ans_r;
      out_drop_r <= drop_r;
      out_used_r <= used_ext[6:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_answer       = out_ans_r;
  assign out_dropped_full = out_drop_r;
  assign out_entries_used = out_used_r;

endmodule

[hdl/timed_id_pair_table.sv]
`timescale 1ns / 1ps
// Insertion-ordered table of up to TABLE_ENTRIES 128-bit identifier pairs,
// each stamped with now_ms when added. One input transaction carries one
// command (add, add if absent, lookup with aging, remove, purge expired,
// clear) and yields exactly one result transaction: answer, dropped_full and
// the entry count after the command (low 7 bits). Entries live in one
// single-port-write, registered-read memory, so every table access takes a
// read state and a second state: a search visits each entry in SRCH_RD and
// SRCH_CMP, and an erase or purge walks the table from the erase point (or
// from the start) with a read and a write pointer, in CMPCT_RD and CMPCT_WR
// per entry, closing gaps in order. Items are processed one at a time; the
// result sits in an output register, so the next transaction is accepted
// while a result still waits for out_ready. An entry is expired when stamp +
// timeout_ms < now_ms with the sum taken without wraparound; lookup skips
// aging when timeout_ms is zero, purge does not. No clearing pass runs after
// reset.
module timed_id_pair_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_command,
  input  logic [tipt_pkg::IdW-1:0]    in_first_id_high,
  input  logic [tipt_pkg::IdW-1:0]    in_first_id_low,
  input  logic [tipt_pkg::IdW-1:0]    in_second_id_high,
  input  logic [tipt_pkg::IdW-1:0]    in_second_id_low,
  input  logic [tipt_pkg::TimeW-1:0]  in_now_ms,
  input  logic [tipt_pkg::ToW-1:0]    in_timeout_ms,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_answer,
  output logic                        out_dropped_full,
  output logic [6:0]                  out_entries_used
);
  import tipt_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: dispatch, search loop, compaction loop, result handoff
  tipt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, pointers, count and output register
  tipt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_first_id_high  (in_first_id_high),
    .in_first_id_low   (in_first_id_low),
    .in_second_id_high (in_second_id_high),
    .in_second_id_low  (in_second_id_low),
    .in_now_ms         (in_now_ms),
    .in_timeout_ms     (in_timeout_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_answer        (out_answer),
    .out_dropped_full  (out_dropped_full),
    .out_entries_used  (out_entries_used)
  );

endmodule

[dv/timed_id_pair_table_chk.sv]
`timescale 1ns / 1ps
module timed_id_pair_table_chk #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [63:0] in_first_id_high,
  input  logic [63:0] in_first_id_low,
  input  logic [63:0] in_second_id_high,
  input  logic [63:0] in_second_id_low,
  input  logic [63:0] in_now_ms,
  input  logic [31:0] in_timeout_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_answer,
  input  logic        out_dropped_full,
  input  logic [6:0]  out_entries_used,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import tipt_pkg::*;

  typedef struct packed {
    logic [63:0] fh, fl, sh, sl, stamp;
  } pair_rec_t;

  typedef struct packed {
    logic       answer;
    logic       dropped;
    logic [6:0] used;
  } table_resp_t;

  pair_rec_t   pair_tbl[$];
  table_resp_t resp_q[$];

  // stamp + timeout < now, no wraparound
  function automatic bit aged_out(logic [63:0] stamp, logic [31:0] to, logic [63:0] now);
    logic [64:0] sum;
    sum = {1'b0, stamp} + {33'b0, to};
    return sum < {1'b0, now};
  endfunction

  function automatic int oldest_match(pair_rec_t key);
    for (int i = 0; i < pair_tbl.size(); i++)
      if (pair_tbl[i].fh == key.fh && pair_tbl[i].fl == key.fl &&
          pair_tbl[i].sh == key.sh && pair_tbl[i].sl == key.sl) return i;
    return -1;
  endfunction

  function automatic table_resp_t apply_command(logic [2:0] cmd, pair_rec_t key,
                                                logic [31:0] to);
    table_resp_t r;
    int pos;
    int i;
    r = '0;
    case (cmd)
      CMD_ADD: begin
        if (pair_tbl.size() >= TABLE_ENTRIES) r.dropped = 1;
        else pair_tbl = {pair_tbl, key};
      end
      CMD_ADD_ABSENT: begin
        if (oldest_match(key) < 0) begin
          if (pair_tbl.size() >= TABLE_ENTRIES) r.dropped = 1;
          else begin
            pair_tbl = {pair_tbl, key};
            r.answer = 1;
          end
        end
      end
      CMD_LOOKUP: begin
        pos = oldest_match(key);
        if (pos >= 0) begin
          if (to != 0 && aged_out(pair_tbl[pos].stamp, to, key.stamp)) pair_tbl.delete(pos);
          else r.answer = 1;
        end
      end
      CMD_REMOVE: begin
        pos = oldest_match(key);
        if (pos >= 0) begin
          pair_tbl.delete(pos);
          r.answer = 1;
        end
      end
      CMD_PURGE: begin
        i = 0;
        while (i < pair_tbl.size()) begin
          if (aged_out(pair_tbl[i].stamp, to, key.stamp)) pair_tbl.delete(i);
          else i++;
        end
      end
      CMD_CLEAR: pair_tbl.delete();
      default: ;
    endcase
    r.used = 7'(pair_tbl.size());
    return r;
  endfunction

  assign pending = resp_q.size();

  always @(posedge clk) begin
    table_resp_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        resp_q = {resp_q, apply_command(in_command,
          '{in_first_id_high, in_first_id_low, in_second_id_high, in_second_id_low,
            in_now_ms}, in_timeout_ms)};
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (resp_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = resp_q.pop_front();
          if (exp_r != {out_answer, out_dropped_full, out_entries_used}) begin
            if (fail_count < 10)
              $display("mismatch: exp ans=%0d drop=%0d used=%0d, got ans=%0d drop=%0d used=%0d",
                       exp_r.answer, exp_r.dropped, exp_r.used,
                       out_answer, out_dropped_full, out_entries_used);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/timed_id_pair_table_tb.sv]
`timescale 1ns / 1ps
module timed_id_pair_table_tb;
  import tipt_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_command = CMD_CLEAR;
  logic [63:0] in_first_id_high = 0, in_first_id_low = 0;
  logic [63:0] in_second_id_high = 0, in_second_id_low = 0;
  logic [63:0] in_now_ms = 0;
  logic [31:0] in_timeout_ms = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        out_answer, out_dropped_full;
  logic [6:0]  out_entries_used;
  int          fail_count, pending, results_seen;
  int          cycle_cnt = 0;
  int          sent = 0;
  bit          rx_hold = 0;   // receiver held off for a long stretch
  bit          no_idle = 0;   // stretch with no idling on either side

  localparam int CycleLimit = 3_000_000;

  // small pool of pairs so matches, duplicates and lookups hit often
  logic [63:0] pool[8][4];

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  timed_id_pair_table dut (.*);

  timed_id_pair_table_chk chk (.*);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, always ready in a no-idle stretch, or a hard hold-off when asked
  always @(posedge clk) begin
    if (rx_hold) out_ready <= 0;
    else if (no_idle) out_ready <= 1;
    else out_ready <= ($urandom_range(99) >= 20);
  end

  // drive one transaction, idle at random first; wait for acceptance
  task automatic send_cmd(logic [2:0] cmd, logic [63:0] fh, logic [63:0] fl,
                          logic [63:0] sh, logic [63:0] sl, logic [63:0] now,
                          logic [31:0] to);
    if (!no_idle)
      while ($urandom_range(99) < 20) begin
        in_valid <= 0;
        @(posedge clk);
      end
    in_valid <= 1;
    in_command <= cmd;
    in_first_id_high <= fh;
    in_first_id_low <= fl;
    in_second_id_high <= sh;
    in_second_id_low <= sl;
    in_now_ms <= now;
    in_timeout_ms <= to;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_pool(logic [2:0] cmd, int k, logic [63:0] now, logic [31:0] to);
    send_cmd(cmd, pool[k][0], pool[k][1], pool[k][2], pool[k][3], now, to);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  logic [63:0] ones = '1;
  logic [63:0] t_now;
  int          k;
  int          r;

  initial begin
    foreach (pool[i, j]) pool[i][j] = rand64();
    pool[0] = '{0, 0, 0, 0};
    pool[1] = '{ones, ones, ones, ones};
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: each command, extremes, aging corner cases
    send_pool(CMD_ADD, 0, 0, 0);
    send_pool(CMD_ADD, 1, ones, '1);
    send_pool(CMD_ADD_ABSENT, 0, 5, 0);                 // present: no add
    send_pool(CMD_ADD_ABSENT, 2, 100, 0);               // absent: added
    send_pool(CMD_LOOKUP, 1, ones, '1);                 // sum overflows: kept
    send_pool(CMD_LOOKUP, 2, 200, 0);                   // timeout zero: no aging
    send_pool(CMD_LOOKUP, 2, 200, 50);                  // expired: erased
    send_pool(CMD_LOOKUP, 2, 200, 50);                  // now gone
    send_pool(CMD_REMOVE, 0, 0, 0);
    send_pool(CMD_REMOVE, 0, 0, 0);                     // absent
    send_cmd(3'd6, ones, 0, ones, 0, 1, 1);             // unused codes
    send_cmd(3'd7, 0, ones, 0, ones, 1, 1);
    send_pool(CMD_ADD, 3, 10, 0);
    send_pool(CMD_ADD, 3, 20, 0);                       // duplicate pair
    send_pool(CMD_PURGE, 0, 15, 0);                     // zero timeout still ages
    send_pool(CMD_LOOKUP, 3, 20, 0);
    send_pool(CMD_CLEAR, 0, 0, 0);
    // fill past capacity: the last two adds are dropped
    for (int i = 0; i < 66; i++) send_pool(CMD_ADD, i % 8, 64'(i), 0);
    send_cmd(CMD_ADD_ABSENT, rand64(), rand64(), rand64(), rand64(), 0, 0); // full
    drain();  // sender pause until all results are back

    // long hold-off on the receiver while the sender keeps offering
    fork
      begin
        rx_hold = 1;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end
      for (int i = 0; i < 10; i++) send_pool(CMD_LOOKUP, i % 8, 1000, 0);
    join

    // random phase: mostly pool pairs, time mostly rising
    t_now = 1000;
    while (sent < 760) begin
      no_idle = (sent > 400 && sent < 480);
      t_now += $urandom_range(40);
      k = $urandom_range(7);
      r = $urandom_range(99);
      if (r < 3) begin
        send_cmd(3'($urandom_range(7)), rand64(), rand64(), rand64(), rand64(), rand64(),
                 $urandom);
      end else if (r < 35) begin
        send_cmd(CMD_ADD, pool[k][0], pool[k][1], pool[k][2], pool[k][3],
                 t_now - $urandom_range(200), $urandom);
      end else if (r < 50) begin
        send_pool(CMD_ADD_ABSENT, k, t_now, $urandom);
      end else if (r < 75) begin
        send_pool(CMD_LOOKUP, k, t_now, $urandom_range(3) == 0 ? 0 : $urandom_range(300));
      end else if (r < 90) begin
        send_pool(CMD_REMOVE, k, t_now, 0);
      end else if (r < 97) begin
        send_pool(CMD_PURGE, k, t_now, $urandom_range(3) == 0 ? $urandom : $urandom_range(300));
      end else begin
        send_pool(CMD_CLEAR, k, t_now, 0);
      end
    end
    no_idle = 0;
    drain();
    repeat (600) @(posedge clk);

    $display("ran %0d command transactions, %0d results: all commands, full table,",
             sent, results_seen);
    $display("aging corners, unused codes, back-pressure and sender pauses");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[files.f]
hdl/tipt_pkg.sv
hdl/tipt_ctrl.sv
hdl/tipt_dpath.sv
hdl/timed_id_pair_table.sv
dv/timed_id_pair_table_chk.sv
dv/timed_id_pair_table_tb.sv
